/* design/nearest_center_cluster_error_unit_assert.svh */
// Assertion macros for the nearest-center cluster error unit.
`ifndef NEAREST_CENTER_CLUSTER_ERROR_UNIT_ASSERT_SVH
`define NEAREST_CENTER_CLUSTER_ERROR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define NCCE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define NCCE_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define NCCE_ASSERT(label, clk, rst, prop)
`define NCCE_ASSERT_RST(label, clk, prop)
`endif
`endif

/* design/ncce_pkg.sv */
package ncce_pkg;
   localparam int MaxCenters = 16;
   localparam int MaxDims    = 4;
   localparam int CoordBits  = 16;
   localparam int CountBits  = 20;
   localparam int SlotBits   = 4;
   localparam int SumBits    = 32 + CountBits;
   localparam int DistBits   = 18;
   localparam int SqBits     = 2 * (CoordBits + 1) + 2;

   localparam logic [1:0] CSR_CENTER_COUNT = 2'd0;
   localparam logic [1:0] CSR_DIM_COUNT    = 2'd1;
   localparam logic [1:0] CSR_ALPHA        = 2'd2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_POINT = 1'b1;

   typedef logic signed [CoordBits-1:0] coord_type;

   typedef struct packed {
      logic                operation;
      logic [SlotBits-1:0] center_slot;
      coord_type           coord_a;
      coord_type           coord_b;
      coord_type           coord_c;
      coord_type           coord_d;
      logic                last_point;
   } req_type;

   typedef struct packed {
      logic [SlotBits-1:0] nearest_center;
      logic [DistBits-1:0] nearest_distance;
      logic                error_valid;
      logic [31:0]         avg_error;
   } rsp_type;

   // Handshake between the top level and the power unit.
   typedef struct packed {
      logic                start;
      logic [DistBits-1:0] distance;
      logic [10:0]         alpha;
   } pow_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] term;
   } pow_rsp_type;
endpackage

/* design/ncce_if.sv */
interface ncce_req_if;
   import ncce_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ncce_rsp_if;
   import ncce_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/ncce_power.sv */
// Sequential (d/4096)^(a/256): log2 by 16 squarings, scaling, exp2 by 16 factors.
module ncce_power (
   input  logic                  clock,
   input  logic                  reset,
   input  ncce_pkg::pow_cmd_type cmd,
   output ncce_pkg::pow_rsp_type rsp
);
   import ncce_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_NORM, S_LOG, S_SCALE, S_ROOT, S_EXP, S_DONE
   } state_type;

   state_type           state_ff;
   logic [5:0]          p_ff;
   logic [4:0]          step_ff;
   logic [32:0]         m_ff;
   logic [15:0]         frac_ff;
   logic [10:0]         alpha_ff;
   logic [DistBits-1:0] d_ff;
   logic signed [31:0]  e_ff;
   logic [31:0]         mant_ff;
   logic [31:0]         term_ff;
   logic                done_ff;
   // Root unit: bit-serial isqrt of c<<30, two bits a cycle.
   logic [61:0]         rv_ff;
   logic [31:0]         rr_ff;
   logic [32:0]         rrem_ff;
   logic [4:0]          rcnt_ff;

   logic [65:0]         sq_w;
   logic [63:0]         mul_w;
   logic signed [31:0]  l_w;
   logic signed [43:0]  y_w;
   logic signed [43:0]  yf_w;
   logic [34:0]         trial_w;
   logic [34:0]         rem2_w;

   // The exp2 factor is the root just produced by the root unit.
   always_comb begin
      sq_w    = {33'd0, m_ff} * {33'd0, m_ff};
      mul_w   = {32'd0, mant_ff} * {32'd0, rr_ff};
      l_w     = ($signed({26'd0, p_ff}) - 32'sd12) * 32'sd65536 + $signed({16'd0, frac_ff});
      y_w     = 44'(l_w) * $signed({33'd0, alpha_ff});
      yf_w    = y_w >>> 8;
      rem2_w  = {rrem_ff, rv_ff[61:60]};
      trial_w = {1'b0, rr_ff, 2'b01};
   end

   assign rsp.done = done_ff;
   assign rsp.term = term_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.start) begin
                  d_ff     <= cmd.distance;
                  alpha_ff <= cmd.alpha;
                  p_ff     <= '0;
                  frac_ff  <= '0;
                  step_ff  <= '0;
                  if (cmd.distance == '0) begin
                     term_ff  <= (cmd.alpha == '0) ? 32'd4096 : 32'd0;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_NORM;
                  end
               end
            end
            // Find the leading one, one bit a cycle from the top.
            S_NORM: begin
               if (d_ff[DistBits-1]) begin
                  p_ff     <= 6'(DistBits - 1 - 32'(step_ff));
                  m_ff     <= {15'd0, d_ff} << 13;
                  step_ff  <= '0;
                  state_ff <= S_LOG;
               end else begin
                  d_ff    <= d_ff << 1;
                  step_ff <= step_ff + 5'd1;
               end
            end
            // One squaring per fraction bit.
            S_LOG: begin
               if (sq_w[61]) begin
                  m_ff    <= 33'(sq_w >> 31);
                  frac_ff <= {frac_ff[14:0], 1'b1};
               end else begin
                  m_ff    <= 33'(sq_w >> 30);
                  frac_ff <= {frac_ff[14:0], 1'b0};
               end
               if (step_ff == 5'd15) state_ff <= S_SCALE;
               step_ff <= step_ff + 5'd1;
            end
            // Underflow and saturation finish at once with the term already set.
            S_SCALE: begin
               e_ff <= 32'(yf_w) + 32'sd786432;
               if (32'(yf_w) + 32'sd786432 < 0) begin
                  term_ff  <= '0;
                  step_ff  <= '0;
                  state_ff <= S_DONE;
               end else if (32'(yf_w) + 32'sd786432 >= 32'sd2097152) begin
                  term_ff  <= 32'hFFFF_FFFF;
                  step_ff  <= '0;
                  state_ff <= S_DONE;
               end else begin
                  mant_ff  <= 32'h4000_0000;
                  step_ff  <= 5'd1;
                  rv_ff    <= 62'h2000_0000_0000_0000;
                  rr_ff    <= '0;
                  rrem_ff  <= '0;
                  rcnt_ff  <= '0;
                  state_ff <= S_ROOT;
               end
            end
            // c = isqrt(c << 30).
            S_ROOT: begin
               if (rem2_w >= trial_w) begin
                  rrem_ff <= 33'(rem2_w - trial_w);
                  rr_ff   <= {rr_ff[30:0], 1'b1};
               end else begin
                  rrem_ff <= rem2_w[32:0];
                  rr_ff   <= {rr_ff[30:0], 1'b0};
               end
               rv_ff   <= rv_ff << 2;
               rcnt_ff <= rcnt_ff + 5'd1;
               if (rcnt_ff == 5'd30) begin
                  state_ff <= S_EXP;
               end
            end
            S_EXP: begin
               if (e_ff[16 - 32'(step_ff)]) mant_ff <= 32'(mul_w >> 30);
               if (step_ff == 5'd16) begin
                  state_ff <= S_DONE;
               end else begin
                  step_ff  <= step_ff + 5'd1;
                  rv_ff    <= {rr_ff, 30'd0};
                  rr_ff    <= '0;
                  rrem_ff  <= '0;
                  rcnt_ff  <= '0;
                  state_ff <= S_ROOT;
               end
            end
            S_DONE: begin
               if (step_ff == 5'd16 && e_ff[20:16] != 5'd31) begin
                  term_ff <= mant_ff >> (5'd30 - e_ff[20:16]);
               end else if (step_ff == 5'd16) begin
                  term_ff <= (mant_ff[31]) ? 32'hFFFF_FFFF : {mant_ff[30:0], 1'b0};
               end
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* design/ncce_divider.sv */
// Restoring divider: floor(num / den) saturated to 32 bits, one quotient bit a cycle.
module ncce_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ncce_pkg::SumBits-1:0]  num,
   input  logic [ncce_pkg::CountBits-1:0] den,
   output logic                          done,
   output logic [31:0]                   quot
);
   import ncce_pkg::*;

   logic [SumBits-1:0]   q_ff;
   logic [CountBits:0]   rem_ff;
   logic [CountBits-1:0] den_ff;
   logic [5:0]           cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [CountBits+1:0] r2_w;

   assign r2_w = {rem_ff, q_ff[SumBits-1]};
   assign done = done_ff;
   assign quot = (|q_ff[SumBits-1:32]) ? 32'hFFFF_FFFF : q_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            q_ff    <= num;
            rem_ff  <= '0;
            den_ff  <= den;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (r2_w >= {2'b0, den_ff}) begin
               rem_ff <= (CountBits+1)'(r2_w - {2'b0, den_ff});
               q_ff   <= {q_ff[SumBits-2:0], 1'b1};
            end else begin
               rem_ff <= r2_w[CountBits:0];
               q_ff   <= {q_ff[SumBits-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(SumBits - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

/* design/nearest_center_cluster_error_unit.sv */
// Nearest-center cluster error unit. A center item is written to the center memory
// and gives no result. A point item starts the center memory read, scans the active
// centers, one per cycle, takes the square root of the smallest squared distance and
// then waits on the power unit for its term: for a nonzero distance it finds the
// leading one, makes 16 squarings for log2 and sixteen exp2 steps, each a square root
// and one multiply. A zero distance or a term that underflows or saturates skips the
// exp2 steps. The last point of a set adds the mean division. One item is processed
// at a time; the result is held in an output register and no item is taken until it leaves.
`include "nearest_center_cluster_error_unit_assert.svh"
module nearest_center_cluster_error_unit (
   input  logic        clock,
   input  logic        reset,
   ncce_req_if.sink    req,
   ncce_rsp_if.source  rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_write_data
);
   import ncce_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_SCAN, S_ROOT, S_POW, S_POWWAIT, S_ACC, S_DIV, S_OUT
   } state_type;

   state_type            state_ff;
   logic [4:0]           ccount_ff;
   logic [2:0]           dcount_ff;
   logic [10:0]          alpha_ff;
   logic [4*CoordBits-1:0] center_mem [MaxCenters];
   logic [4*CoordBits-1:0] rd_ff;
   req_type              item_ff;
   logic [4:0]           idx_ff;
   logic [4:0]           nc_ff;
   logic [3:0]           cidx_ff;
   logic [SqBits-1:0]    best_ff;
   logic [SlotBits-1:0]  besti_ff;
   logic [SumBits-1:0]   sum_ff;
   logic [CountBits-1:0] total_ff;
   logic [SqBits-1:0]    rv_ff;
   logic [DistBits+1:0]  rr_ff;
   logic [SqBits/2+2:0]  rrem_ff;
   logic [5:0]           rcnt_ff;
   rsp_type              out_ff;
   logic                 out_valid_ff;
   pow_cmd_type          pcmd;
   pow_rsp_type          prsp;
   logic                 div_start;
   logic                 div_done;
   logic [31:0]          div_quot;
   logic [SqBits-1:0]    sq_w;
   logic [SqBits/2+4:0]  rem2_w;
   logic [SqBits/2+4:0]  trial_w;
   logic [2:0]           nd_w;
   logic [SumBits:0]     sum_w;
   logic [DistBits-1:0]  dist_w;

   // Squared distance of the item to the center just read.
   always_comb begin
      logic signed [CoordBits:0]   df;
      logic [CoordBits:0]          ad;
      logic [2*CoordBits+1:0]      sq_lane;
      coord_type                   pc [4];
      coord_type                   cc;
      nd_w = (dcount_ff == 3'd0) ? 3'd1 : (dcount_ff > 3'(MaxDims)) ? 3'(MaxDims) : dcount_ff;
      pc[0] = item_ff.coord_a;
      pc[1] = item_ff.coord_b;
      pc[2] = item_ff.coord_c;
      pc[3] = item_ff.coord_d;
      sq_w = '0;
      for (int j = 0; j < 4; j++) begin
         cc = rd_ff[j*CoordBits +: CoordBits];
         df = $signed({pc[j][CoordBits-1], pc[j]}) - $signed({cc[CoordBits-1], cc});
         ad = df[CoordBits] ? (CoordBits+1)'(-df) : df;
         sq_lane = ad * ad;
         if (3'(j) < nd_w) sq_w = sq_w + SqBits'(sq_lane);
      end
   end

   assign dist_w  = (|rr_ff[DistBits+1:DistBits]) ? '1 : rr_ff[DistBits-1:0];
   assign rem2_w  = {rrem_ff, rv_ff[SqBits-1:SqBits-2]};
   assign trial_w = (SqBits/2+5)'({rr_ff, 2'b01});
   assign sum_w   = {1'b0, sum_ff} + {{(SumBits-31){1'b0}}, prsp.term};

   assign pcmd.start    = (state_ff == S_POW);
   assign pcmd.distance = dist_w;
   assign pcmd.alpha    = alpha_ff;
   assign div_start  = (state_ff == S_ACC) && item_ff.last_point;

   ncce_power u_power (.clock(clock), .reset(reset), .cmd(pcmd), .rsp(prsp));
   ncce_divider u_div (.clock(clock), .reset(reset), .start(div_start), .num(sum_ff),
      .den(total_ff), .done(div_done), .quot(div_quot));

   assign req.ready   = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   // Center memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready && req.payload.operation == OP_LOAD) begin
         center_mem[req.payload.center_slot] <= {req.payload.coord_d, req.payload.coord_c,
            req.payload.coord_b, req.payload.coord_a};
      end
      rd_ff <= center_mem[cidx_ff];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ccount_ff <= 5'd1;
         dcount_ff <= 3'd4;
         alpha_ff  <= 11'd256;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CENTER_COUNT: ccount_ff <= csr_write_data[4:0];
            CSR_DIM_COUNT:    dcount_ff <= csr_write_data[2:0];
            CSR_ALPHA:        alpha_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Sequencer for one item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         sum_ff       <= '0;
         total_ff     <= '0;
         cidx_ff      <= '0;
      end else begin
         if (rsp.valid && rsp.ready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               cidx_ff <= '0;
               if (req.valid && req.ready && req.payload.operation == OP_POINT) begin
                  item_ff  <= req.payload;
                  nc_ff    <= (ccount_ff == 5'd0) ? 5'd1 :
                              (ccount_ff > 5'(MaxCenters)) ? 5'(MaxCenters) : ccount_ff;
                  idx_ff   <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               cidx_ff  <= cidx_ff + 4'd1;
               state_ff <= S_SCAN;
            end
            // One center compared per cycle; read of the next is in flight.
            S_SCAN: begin
               if (idx_ff == 5'd0 || sq_w < best_ff) begin
                  best_ff  <= sq_w;
                  besti_ff <= idx_ff[3:0];
               end
               cidx_ff <= cidx_ff + 4'd1;
               idx_ff  <= idx_ff + 5'd1;
               if (idx_ff + 5'd1 == nc_ff) begin
                  rv_ff    <= (idx_ff == 5'd0 || sq_w < best_ff) ? sq_w : best_ff;
                  rr_ff    <= '0;
                  rrem_ff  <= '0;
                  rcnt_ff  <= '0;
                  state_ff <= S_ROOT;
               end
            end
            S_ROOT: begin
               if (rem2_w >= trial_w) begin
                  rrem_ff <= (SqBits/2+3)'(rem2_w - trial_w);
                  rr_ff   <= {rr_ff[DistBits:0], 1'b1};
               end else begin
                  rrem_ff <= rem2_w[SqBits/2+2:0];
                  rr_ff   <= {rr_ff[DistBits:0], 1'b0};
               end
               rv_ff   <= rv_ff << 2;
               rcnt_ff <= rcnt_ff + 6'd1;
               if (rcnt_ff == 6'(SqBits/2 - 1)) state_ff <= S_POW;
            end
            S_POW: state_ff <= S_POWWAIT;
            S_POWWAIT: begin
               if (prsp.done) begin
                  sum_ff   <= sum_w[SumBits] ? '1 : sum_w[SumBits-1:0];
                  if (total_ff != '1) total_ff <= total_ff + 1'b1;
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               out_ff.nearest_center   <= besti_ff;
               out_ff.nearest_distance <= dist_w;
               out_ff.error_valid      <= item_ff.last_point;
               out_ff.avg_error        <= '0;
               state_ff <= item_ff.last_point ? S_DIV : S_OUT;
            end
            S_DIV: begin
               if (div_done) begin
                  out_ff.avg_error <= div_quot;
                  sum_ff   <= '0;
                  total_ff <= '0;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               out_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `NCCE_ASSERT(a_no_accept_busy, clock, reset, (state_ff != S_IDLE) |-> !req.ready)
   `NCCE_ASSERT(a_out_hold, clock, reset, (rsp.valid && !rsp.ready) |=> rsp.valid)
   `NCCE_ASSERT(a_scan_range, clock, reset, (state_ff == S_SCAN) |-> (idx_ff < nc_ff))
   `NCCE_ASSERT_RST(a_reset_idle, clock, reset |=> (state_ff == S_IDLE))
endmodule

/* tb/tb_nearest_center_cluster_error_unit.sv */
module tb_nearest_center_cluster_error_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ncce_pkg::*;

   localparam int IdleLimit   = 20000;
   localparam int HoldCycles  = 1500;
   localparam int SettleDelay = 20;
   localparam logic [1:0] CsrNoRegister = 2'd3;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [10:0] csr_write_data;

   ncce_req_if req_bus ();
   ncce_rsp_if rsp_bus ();

   nearest_center_cluster_error_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus.sink),
      .rsp              (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the block's state and registers.
   coord_type          center_mem [MaxCenters][MaxDims];
   logic [SumBits-1:0] term_sum;
   logic [CountBits-1:0] points_seen;
   logic [4:0]         active_centers;
   logic [2:0]         active_dims;
   logic [10:0]        alpha_q38;

   req_type pending_items [$];
   rsp_type expected_results [$];
   int      error_count;
   int      idle_cycles;
   int      results_seen;
   bit      burst_mode;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Report one mismatch and count it.
   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // 2^(f/65536) in Q1.30, built from successive square roots of 2.
   function automatic longint unsigned exp2_of_fraction(int unsigned f);
      longint unsigned mant;
      longint unsigned factor;
      mant   = 64'd1 << 30;
      factor = 64'd1 << 31;
      for (int i = 1; i <= 16; i++) begin
         factor = int_sqrt(factor << 30);
         if ((f >> (16 - i)) & 1) mant = (mant * factor) >> 30;
      end
      return mant;
   endfunction

   // (d/4096)^(a/256) in Q20.12 through log2 and exp2, saturating.
   function automatic longint unsigned distance_power(longint unsigned d, int unsigned a);
      int              p;
      longint unsigned m;
      longint unsigned mant;
      longint unsigned frac;
      longint          l;
      longint          y;
      longint          e;
      int unsigned     k;
      if (d == 0) return (a == 0) ? 64'd4096 : 64'd0;
      p = 0;
      while (p < 40 && (d >> (p + 1)) != 0) p++;
      m    = d << (30 - p);
      frac = 0;
      for (int i = 0; i < 16; i++) begin
         m    = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m    = m >> 1;
            frac = frac | 1;
         end
      end
      l = (longint'(p) - 12) * 65536 + longint'(frac);
      y = l * longint'(a);
      y = (y >= 0) ? (y / 256) : -((-y + 255) / 256);
      e = y + 12 * 65536;
      if (e < 0) return 0;
      k = int'(e >>> 16);
      if (k >= 32) return 64'hFFFF_FFFF;
      mant = exp2_of_fraction(int'(e & 64'hFFFF));
      if (k <= 30) mant = mant >> (30 - k);
      else mant = mant << (k - 30);
      return (mant > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : mant;
   endfunction

   // Apply one accepted item to the shadow state; queue its result, if any.
   function automatic void predict_assignment(req_type it);
      coord_type       pt [MaxDims];
      int              nc;
      int              nd;
      int              best;
      longint unsigned best_sq;
      longint unsigned sq;
      longint          df;
      longint unsigned distance;
      longint unsigned term;
      longint unsigned sum_max;
      longint unsigned mean;
      rsp_type         r;
      pt[0] = it.coord_a;
      pt[1] = it.coord_b;
      pt[2] = it.coord_c;
      pt[3] = it.coord_d;
      if (it.operation == OP_LOAD) begin
         for (int j = 0; j < MaxDims; j++) center_mem[it.center_slot][j] = pt[j];
         return;
      end
      nc = (active_centers < 1) ? 1 : (active_centers > MaxCenters) ? MaxCenters
                                                                   : active_centers;
      nd = (active_dims < 1) ? 1 : (active_dims > MaxDims) ? MaxDims : active_dims;
      best    = 0;
      best_sq = 0;
      for (int c = 0; c < nc; c++) begin
         sq = 0;
         for (int j = 0; j < nd; j++) begin
            df = longint'(pt[j]) - longint'(center_mem[c][j]);
            if (df < 0) df = -df;
            sq += longint'(df) * longint'(df);
         end
         if (c == 0 || sq < best_sq) begin
            best_sq = sq;
            best    = c;
         end
      end
      distance = int_sqrt(best_sq);
      if (distance > 262143) distance = 262143;
      term    = distance_power(distance, alpha_q38);
      sum_max = (64'd1 << SumBits) - 1;
      term_sum = (term_sum > sum_max - term) ? sum_max[SumBits-1:0] : term_sum + term;
      if (points_seen != '1) points_seen++;
      r.nearest_center   = best[SlotBits-1:0];
      r.nearest_distance = distance[DistBits-1:0];
      r.error_valid      = it.last_point;
      r.avg_error        = '0;
      if (it.last_point) begin
         mean = 64'(term_sum) / 64'(points_seen);
         r.avg_error = (mean > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mean[31:0];
         term_sum    = '0;
         points_seen = '0;
      end
      expected_results = {expected_results, r};
   endfunction

   // Driver: present pending items with a random gap after each one, none in burst mode.
   int send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) predict_assignment(req_bus.payload);
         if (req_bus.valid && !req_bus.ready) begin
            // Hold the offered item.
         end else if (send_gap != 0) begin
            req_bus.valid <= 1'b0;
            send_gap      <= send_gap - 1;
         end else if (pending_items.size() != 0) begin
            req_bus.payload <= pending_items.pop_front();
            req_bus.valid   <= 1'b1;
            send_gap        <= burst_mode ? 0 : $urandom_range(0, 6);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Monitor: check each result and stall the result side at random, except in burst mode.
   int stall_left;
   int hold_left;
   bit hold_done;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
         hold_left     <= 0;
         hold_done     <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               rsp_type want;
               want = expected_results.pop_front();
               if (rsp_bus.payload.nearest_center != want.nearest_center)
                  report_mismatch("nearest_center", rsp_bus.payload.nearest_center,
                                  want.nearest_center);
               if (rsp_bus.payload.nearest_distance != want.nearest_distance)
                  report_mismatch("nearest_distance", rsp_bus.payload.nearest_distance,
                                  want.nearest_distance);
               if (rsp_bus.payload.error_valid != want.error_valid)
                  report_mismatch("error_valid", rsp_bus.payload.error_valid,
                                  want.error_valid);
               if (rsp_bus.payload.avg_error != want.avg_error)
                  report_mismatch("avg_error", rsp_bus.payload.avg_error,
                                  want.avg_error);
            end
         end
         // One long hold-off once the run is under way, so the input backs up.
         if (!hold_done && results_seen == 40) begin
            hold_done     <= 1'b1;
            hold_left     <= HoldCycles;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= (hold_left == 1);
         end else if (rsp_bus.valid && rsp_bus.ready) begin
            int s;
            s = burst_mode ? 0 : $urandom_range(0, 6);
            stall_left    <= s;
            rsp_bus.ready <= (s == 0);
         end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            rsp_bus.ready <= (stall_left == 1);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no item moving on either side.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("tb_nearest_center_cluster_error_unit: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_register(logic [1:0] idx, logic [10:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_CENTER_COUNT: active_centers = value[4:0];
         CSR_DIM_COUNT:    active_dims    = value[2:0];
         CSR_ALPHA:        alpha_q38      = value;
         default: ;
      endcase
   endtask

   task automatic set_registers(int nc, int nd, int a);
      write_register(CSR_CENTER_COUNT, 11'(nc));
      write_register(CSR_DIM_COUNT, 11'(nd));
      write_register(CSR_ALPHA, 11'(a));
   endtask

   // Wait until every item is sent and every result is back, then settle.
   task automatic drain_block();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_bus.valid || expected_results.size() != 0);
      repeat (SettleDelay) @(posedge clock);
   endtask

   function automatic req_type make_item(logic op, int slot, int a, int b, int c, int d,
                                         logic last);
      req_type it;
      it.operation   = op;
      it.center_slot = slot[SlotBits-1:0];
      it.coord_a     = a[15:0];
      it.coord_b     = b[15:0];
      it.coord_c     = c[15:0];
      it.coord_d     = d[15:0];
      it.last_point  = last;
      return it;
   endfunction

   function automatic int pick_coord();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         2: return int'($urandom_range(0, 255)) - 128;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // Append one item to the driver's queue.
   function automatic void queue_item(req_type it);
      pending_items = {pending_items, it};
   endfunction

   // Random phase: mostly points, some center reloads, sets of a few points.
   task automatic queue_random_items(int count);
      logic op;
      for (int n = 0; n < count; n++) begin
         op = ($urandom_range(0, 4) == 0) ? OP_LOAD : OP_POINT;
         queue_item(make_item(op, $urandom_range(0, 15), pick_coord(),
                              pick_coord(), pick_coord(), pick_coord(),
                              $urandom_range(0, 5) == 0));
      end
      queue_item(make_item(OP_POINT, 0, pick_coord(), pick_coord(),
                           pick_coord(), pick_coord(), 1'b1));
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_bus.valid    = 1'b0;
      req_bus.payload  = '0;
      rsp_bus.ready    = 1'b0;
      error_count      = 0;
      idle_cycles      = 0;
      results_seen     = 0;
      burst_mode       = 1'b0;
      term_sum         = '0;
      points_seen      = '0;
      active_centers   = 5'd1;
      active_dims      = 3'd4;
      alpha_q38        = 11'd256;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: fill every slot, then extremes, ties and zero distance.
      set_registers(16, 4, 256);
      queue_item(make_item(OP_LOAD, 0, 32767, 32767, 32767, 32767, 1'b0));
      queue_item(make_item(OP_LOAD, 1, -32768, -32768, -32768, -32768, 1'b0));
      queue_item(make_item(OP_LOAD, 2, 0, 0, 0, 0, 1'b0));
      queue_item(make_item(OP_LOAD, 3, 0, 0, 0, 0, 1'b0));
      for (int s = 4; s < MaxCenters; s++)
         queue_item(make_item(OP_LOAD, s, pick_coord(), pick_coord(),
                              pick_coord(), pick_coord(), 1'b0));
      queue_item(make_item(OP_POINT, 0, 0, 0, 0, 0, 1'b0));
      queue_item(make_item(OP_POINT, 0, 32767, 32767, 32767, 32767, 1'b0));
      queue_item(make_item(OP_POINT, 0, -32768, -32768, -32768, -32768, 1'b0));
      queue_item(make_item(OP_POINT, 0, 32767, -32768, 32767, -32768, 1'b0));
      queue_item(make_item(OP_POINT, 0, 100, -100, 4096, -4096, 1'b1));
      drain_block();

      // Alpha zero, one dimension, full and single center counts.
      set_registers(16, 4, 0);
      queue_item(make_item(OP_POINT, 0, 0, 0, 0, 0, 1'b0));
      queue_item(make_item(OP_POINT, 0, 5, 5, 5, 5, 1'b1));
      queue_random_items(60);
      drain_block();

      set_registers(1, 1, 2047);
      queue_random_items(70);
      drain_block();

      // Out-of-range counts act as their nearest legal value.
      burst_mode = 1'b1;
      set_registers(0, 0, 1);
      write_register(CsrNoRegister, 11'h7FF);
      queue_random_items(60);
      drain_block();

      burst_mode = 1'b0;
      set_registers(31, 7, 512);
      queue_random_items(80);
      drain_block();

      for (int ph = 0; ph < 3; ph++) begin
         burst_mode = (ph == 1);
         set_registers($urandom_range(1, 16), $urandom_range(1, 4), $urandom_range(1, 2047));
         queue_random_items(70);
         drain_block();
      end

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("tb_nearest_center_cluster_error_unit: done, clean");
      end else begin
         $display("tb_nearest_center_cluster_error_unit: done, errors");
      end
      $finish;
   end
endmodule

/* nearest_center_cluster_error_unit.f */
+incdir+design
design/ncce_pkg.sv
design/ncce_if.sv
design/ncce_power.sv
design/ncce_divider.sv
design/nearest_center_cluster_error_unit.sv
tb/tb_nearest_center_cluster_error_unit.sv
